[hw/rtl/assert_macros.svh]
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/mastep_pkg.sv]
// Shared types, codes and constants for the step/direction move generator.
package mastep_pkg;

    localparam int AXES_DEFAULT          = 4;
    localparam int POSITION_BITS_DEFAULT = 25;

    localparam int OP_W       = 2;
    localparam int SEL_W      = 2;
    localparam int FIELD_POS_W = 25;
    localparam int INTERVAL_W = 16;
    localparam int LINE_W     = 4;

    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd750;

    localparam logic [OP_W-1:0] OP_TICK       = 2'd0;
    localparam logic [OP_W-1:0] OP_SET_TARGET = 2'd1;
    localparam logic [OP_W-1:0] OP_START_MOVE = 2'd2;
    localparam logic [OP_W-1:0] OP_STOP_AXIS  = 2'd3;

    typedef struct packed {
        logic                   tick;
        logic                   set_target;
        logic                   start_move;
        logic                   stop_move;
        logic [FIELD_POS_W-1:0] target;
    } axis_cmd_t;

    typedef struct packed {
        logic pulse;
        logic dir;
        logic en;
        logic busy;
        logic done;
    } axis_status_t;

endpackage

[hw/rtl/mastep_axis.sv]
// One axis: position, target, interval counter and line state.
module mastep_axis #(
    parameter int POSITION_BITS = mastep_pkg::POSITION_BITS_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  mastep_pkg::axis_cmd_t                 cmd,
    input  logic [mastep_pkg::INTERVAL_W-1:0]     interval,
    output mastep_pkg::axis_status_t              status_next,
    output logic [POSITION_BITS-1:0]              position_next
);
    import mastep_pkg::*;

    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] tgt_reg, tgt_next;
    logic [INTERVAL_W-1:0]    count_reg, count_next;
    logic [INTERVAL_W-1:0]    count_inc;
    axis_status_t             stat_reg, stat_next;

    assign count_inc = count_reg + 1'b1;

    always_comb
    begin
        pos_next   = pos_reg;
        tgt_next   = tgt_reg;
        count_next = count_reg;
        stat_next  = stat_reg;
        if (cmd.tick && stat_reg.busy)
        begin
            if (count_inc < interval)
            begin
                count_next = count_inc;
            end
            else
            begin
                count_next = '0;
                if (pos_reg != tgt_reg)
                begin
                    stat_next.dir   = (pos_reg < tgt_reg);
                    stat_next.pulse = ~stat_reg.pulse;
                    pos_next = (pos_reg < tgt_reg) ? pos_reg + 1'b1 : pos_reg - 1'b1;
                end
                if (pos_next == tgt_reg)
                begin
                    stat_next.done = 1'b1;
                    stat_next.busy = 1'b0;
                end
            end
        end
        if (cmd.set_target)
        begin
            tgt_next       = POSITION_BITS'(cmd.target);
            stat_next.done = 1'b0;
        end
        if (cmd.start_move)
        begin
            if (pos_reg == tgt_reg)
            begin
                stat_next.done = 1'b1;
                stat_next.en   = 1'b0;
                stat_next.busy = 1'b0;
            end
            else
            begin
                stat_next.dir  = (pos_reg < tgt_reg);
                stat_next.en   = 1'b1;
                stat_next.busy = 1'b1;
                stat_next.done = 1'b0;
                count_next     = '0;
            end
        end
        if (cmd.stop_move)
        begin
            stat_next.busy = 1'b0;
            stat_next.en   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            tgt_reg   <= '0;
            count_reg <= '0;
            stat_reg  <= '{pulse: 1'b0, dir: 1'b1, en: 1'b0, busy: 1'b0, done: 1'b0};
        end
        else
        begin
            pos_reg   <= pos_next;
            tgt_reg   <= tgt_next;
            count_reg <= count_next;
            stat_reg  <= stat_next;
        end
    end

    assign status_next   = stat_next;
    assign position_next = pos_next;

endmodule

[hw/rtl/multi_axis_step_dir_move_generator_core.sv]
// Top level of the multi-axis step/direction move generator.
// Drives step, direction and enable lines for AXES stepper axes. Each request
// is a timer tick, a target write, a move start or an axis stop; every request
// yields exactly one result holding the pulse, direction, enable, busy and
// done lines of axes 0 to 3 plus the position of the addressed axis after the
// request (zero when the axis number is not below AXES). Positions count in
// units of 1/500 revolution, one unit per pulse toggle. Throughput is one
// request per clock: a request is captured in the input register, then all
// axes update their state in a single pass as it is processed and the result
// lands in the output register. Both registers advance independently of a
// stalled consumer while there is room, giving full rate whenever out_ready
// stays high. The pulse interval register resets to 750 ticks; a value of 0
// behaves like 1. Write it only while no request is in flight.
module multi_axis_step_dir_move_generator_core #(
    parameter int AXES          = mastep_pkg::AXES_DEFAULT,
    parameter int POSITION_BITS = mastep_pkg::POSITION_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mastep_pkg::INTERVAL_W-1:0]   cfg_pulse_interval_ticks,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [mastep_pkg::OP_W-1:0]         operation,
    input  logic [mastep_pkg::SEL_W-1:0]        axis_select,
    input  logic [mastep_pkg::FIELD_POS_W-1:0]  target_position,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [mastep_pkg::LINE_W-1:0]       pulse_lines,
    output logic [mastep_pkg::LINE_W-1:0]       direction_lines,
    output logic [mastep_pkg::LINE_W-1:0]       enable_lines,
    output logic [mastep_pkg::LINE_W-1:0]       busy_lines,
    output logic [mastep_pkg::LINE_W-1:0]       done_lines,
    output logic [mastep_pkg::FIELD_POS_W-1:0]  selected_position
);
    import mastep_pkg::*;

    // Configuration register; always ready.
    logic [INTERVAL_W-1:0] interval_reg;

    // Input stage.
    logic                   stage_valid_reg, stage_valid_next;
    logic [OP_W-1:0]        stage_op_reg;
    logic [SEL_W-1:0]       stage_sel_reg;
    logic [FIELD_POS_W-1:0] stage_tgt_reg;

    // Output stage.
    logic                   out_valid_reg, out_valid_next;
    logic [LINE_W-1:0]      pulse_reg, dir_reg, en_reg, busy_reg, done_reg;
    logic [FIELD_POS_W-1:0] sel_pos_reg;

    logic advance;
    logic in_accept;

    axis_status_t             status_arr [AXES];
    logic [POSITION_BITS-1:0] pos_arr    [AXES];
    logic [LINE_W-1:0]        pulse_bits, dir_bits, en_bits, busy_bits, done_bits;
    logic [POSITION_BITS-1:0] sel_pos;
    logic                     sel_valid;

    assign cfg_ready = 1'b1;

    // Process the staged request when the output register is free or draining.
    assign advance   = stage_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !stage_valid_reg || advance;
    assign in_accept = in_valid && in_ready;

    assign stage_valid_next = in_accept || (stage_valid_reg && !advance);
    assign out_valid_next   = advance || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg    <= INTERVAL_RESET;
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                interval_reg <= cfg_pulse_interval_ticks;
            end
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Hold the request payload until it is processed.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            stage_op_reg  <= operation;
            stage_sel_reg <= axis_select;
            stage_tgt_reg <= target_position;
        end
    end

    // One axis unit per axis; commands are gated by advance, and all but the tick by the axis match.
    for (genvar a = 0; a < AXES; a++)
    begin : g_axis
        axis_cmd_t cmd;
        logic      hit;

        assign hit            = advance && (int'(stage_sel_reg) == a);
        assign cmd.tick       = advance && (stage_op_reg == OP_TICK);
        assign cmd.set_target = hit && (stage_op_reg == OP_SET_TARGET);
        assign cmd.start_move = hit && (stage_op_reg == OP_START_MOVE);
        assign cmd.stop_move  = hit && (stage_op_reg == OP_STOP_AXIS);
        assign cmd.target     = stage_tgt_reg;

        mastep_axis #(
            .POSITION_BITS (POSITION_BITS)
        ) u_axis (
            .clk           (clk),
            .rst_n         (rst_n),
            .cmd           (cmd),
            .interval      (interval_reg),
            .status_next   (status_arr[a]),
            .position_next (pos_arr[a])
        );
    end

    // Gather the lines of the first four axes; absent axes read as zero.
    for (genvar i = 0; i < LINE_W; i++)
    begin : g_lines
        if (i < AXES)
        begin : g_present
            assign pulse_bits[i] = status_arr[i].pulse;
            assign dir_bits[i]   = status_arr[i].dir;
            assign en_bits[i]    = status_arr[i].en;
            assign busy_bits[i]  = status_arr[i].busy;
            assign done_bits[i]  = status_arr[i].done;
        end
        else
        begin : g_absent
            assign pulse_bits[i] = 1'b0;
            assign dir_bits[i]   = 1'b0;
            assign en_bits[i]    = 1'b0;
            assign busy_bits[i]  = 1'b0;
            assign done_bits[i]  = 1'b0;
        end
    end

    // Select the addressed axis position; out-of-range selects read zero.
    always_comb
    begin
        sel_pos   = '0;
        sel_valid = 1'b0;
        for (int a = 0; a < AXES; a++)
        begin
            if (int'(stage_sel_reg) == a)
            begin
                sel_pos   = pos_arr[a];
                sel_valid = 1'b1;
            end
        end
    end

    // Load the result register as the request is processed.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pulse_reg   <= pulse_bits;
            dir_reg     <= dir_bits;
            en_reg      <= en_bits;
            busy_reg    <= busy_bits;
            done_reg    <= done_bits;
            sel_pos_reg <= sel_valid ? FIELD_POS_W'(sel_pos) : '0;
        end
    end

    assign out_valid         = out_valid_reg;
    assign pulse_lines       = pulse_reg;
    assign direction_lines   = dir_reg;
    assign enable_lines      = en_reg;
    assign busy_lines        = busy_reg;
    assign done_lines        = done_reg;
    assign selected_position = sel_pos_reg;

endmodule

[hw/rtl/mastep_checker.sv]
// Port-level checker for the move generator, bound to the top level.
`include "assert_macros.svh"

module mastep_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic [mastep_pkg::LINE_W-1:0]       enable_lines,
    input logic [mastep_pkg::LINE_W-1:0]       busy_lines,
    input logic [mastep_pkg::LINE_W-1:0]       done_lines,
    input logic [mastep_pkg::FIELD_POS_W-1:0]  selected_position
);
    import mastep_pkg::*;

    // An axis is never busy and done at once.
    `ASSERT_SAME(a_busy_not_done, clk, rst_n, out_valid,
        (busy_lines & done_lines) == '0, "axis reports busy and done together")

    // A busy axis always has its driver enabled.
    `ASSERT_SAME(a_busy_enabled, clk, rst_n, out_valid,
        (busy_lines & ~enable_lines) == '0, "busy axis with driver disabled")

    // A stalled result stays valid and keeps its position and busy lines.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(selected_position) && $stable(busy_lines),
        "stalled result changed")

endmodule

bind multi_axis_step_dir_move_generator_core mastep_checker u_mastep_checker (.*);
